// ===== rtl/core/slis_pkg.sv =====
// Package for the strict LIS length engine: field widths, the sequencer state
// type and the request and response words between the top level and the scan unit.
// No dependencies.
package slis_pkg;

    localparam int VAL_W  = 32;
    localparam int CNT_W  = 6;
    localparam int HALF_W = 5;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_len;
    typedef logic [HALF_W-1:0]       t_half;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic   start;
        t_value value;
        t_len   count;
    } t_scan_req;

    typedef struct packed {
        logic done;
        t_len len;
    } t_scan_rsp;

endpackage

// ===== rtl/core/slis_if.sv =====
// Valid/ready channel interfaces for the input and result words of the engine.
// Depends on slis_pkg.
interface slis_in_if;
    logic                  valid;
    logic                  ready;
    slis_pkg::t_value      value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface slis_out_if;
    logic                  valid;
    logic                  ready;
    slis_pkg::t_len        lis_length;
    slis_pkg::t_half       half_remainder;
    logic                  overflowed;

    modport source (output valid, output lis_length, output half_remainder,
                    output overflowed, input ready);
    modport sink   (input valid, input lis_length, input half_remainder,
                    input overflowed, output ready);
endinterface

// ===== rtl/core/slis_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module slis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/slis_scan.sv =====
// Scan unit: reads every stored element once and keeps the best ending length
// among smaller values. Depends on slis_pkg; drives the read port of slis_ram.
module slis_scan #(
    parameter int MAX_LEN = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  slis_pkg::t_scan_req        i_req,
    output slis_pkg::t_scan_rsp        o_rsp,
    output logic                       o_rd_en,
    output logic [$clog2(MAX_LEN)-1:0] o_rd_addr,
    input  slis_pkg::t_value           i_rd_value,
    input  slis_pkg::t_len             i_rd_len
);
    import slis_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);

    logic   r_busy;
    logic   r_cmp_vld;
    t_len   r_idx;
    t_len   r_count;
    t_value r_value;
    t_len   r_len;

    logic   w_issue;
    t_len   w_cand;
    logic   w_better;
    logic   w_finish;

    assign w_issue   = r_busy && (r_idx < r_count);
    assign w_cand    = i_rd_len + t_len'(1);
    assign w_better  = r_cmp_vld && (i_rd_value < r_value) && (w_cand > r_len);
    assign w_finish  = r_busy && !w_issue && !r_cmp_vld;

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_idx[IDX_W-1:0];
    assign o_rsp.done = w_finish;
    assign o_rsp.len  = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= w_issue;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_idx   <= '0;
            r_count <= i_req.count;
            r_value <= i_req.value;
            r_len   <= t_len'(1);
        end else begin
            if (w_issue) begin
                r_idx <= r_idx + t_len'(1);
            end
            if (w_better) begin
                r_len <= w_cand;
            end
        end
    end

endmodule

// ===== rtl/core/strict_lis_length_engine_core.sv =====
// An element is accepted only while the engine is idle, so the next one waits until the
// scan of the store for this one has finished; the scan reads each stored element once
// through the single read port of the store. An element met with a full store is dropped.
// A last element then loads the result word once the receiver has taken the previous one.
// Reset (synchronous, active low) clears the count, best length, overflow flag, state and
// result valid; the store is left as it is. Depends on slis_pkg, slis_if, slis_scan, slis_ram.
module strict_lis_length_engine_core #(
    parameter int MAX_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slis_in_if.sink     i_in,
    slis_out_if.source  o_out
);
    import slis_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int MEM_W = VAL_W + CNT_W;

    t_state    r_state;
    t_state    n_state;
    t_len      r_count;
    t_len      r_best;
    logic      r_ovf;
    t_value    r_value;
    logic      r_last;
    logic      r_out_valid;
    t_len      r_out_len;
    t_half     r_out_half;
    logic      r_out_ovf;

    logic      w_accept;
    logic      w_full;
    logic      w_emit;
    logic      w_store;
    logic [CNT_W:0] w_half_sum;

    t_scan_req w_req;
    t_scan_rsp w_rsp;

    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic [MEM_W-1:0] w_rd_data;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == t_len'(MAX_LEN));
    assign w_store    = (r_state == ST_SCAN) && w_rsp.done;
    assign w_emit     = (r_state == ST_RESULT) && (!r_out_valid || o_out.ready);
    assign w_half_sum = {1'b0, r_count} + (CNT_W+1)'(1) - {1'b0, r_best};

    assign w_req.start = w_accept && !w_full;
    assign w_req.value = i_in.value;
    assign w_req.count = r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!w_full) begin
                        n_state = ST_SCAN;
                    end else if (i_in.last) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (w_rsp.done) begin
                    n_state = r_last ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && w_full) begin
                r_ovf <= 1'b1;
            end
            if (w_store) begin
                r_count <= r_count + t_len'(1);
                if (w_rsp.len > r_best) begin
                    r_best <= w_rsp.len;
                end
            end
            if (w_emit) begin
                r_count     <= '0;
                r_best      <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_in.value;
            r_last  <= i_in.last;
        end
        if (w_emit) begin
            r_out_len  <= r_best;
            r_out_half <= w_half_sum[HALF_W:1];
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.lis_length     = r_out_len;
    assign o_out.half_remainder = r_out_half;
    assign o_out.overflowed     = r_out_ovf;

    slis_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rsp      (w_rsp),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_value (w_rd_data[MEM_W-1:CNT_W]),
        .i_rd_len   (w_rd_data[CNT_W-1:0])
    );

    slis_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({r_value, w_rsp.len}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule
